@@ sv/full_to_sparse_grid_index_macros.svh @@
// Assertion helpers for the top RTL file of the grid index block.
`ifndef FULL_TO_SPARSE_GRID_INDEX_MACROS_SVH
`define FULL_TO_SPARSE_GRID_INDEX_MACROS_SVH

// Check a property on every rising edge of clk, off while arst_n is low.
`define FTSG_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge of clk.
`define FTSG_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/ftsg_pkg.sv @@
`default_nettype none

package ftsg_pkg;

	localparam int IDX_W         = 24;
	localparam int SIDX_W        = 15;
	localparam int LEVEL_W       = 4;
	localparam int MAX_LEVEL_DEF = 10;
	localparam int PDATA_W       = 32;
	localparam int PADDR_W       = 3;

	localparam logic [LEVEL_W-1:0] LEVEL_RESET = LEVEL_W'(4);

	// register index, taken from paddr[2]
	localparam logic REG_LEVEL = 1'b0;

	// rectangle order within one rank of the hyperbolic cross
	localparam int RECT_RIGHT = 0;
	localparam int RECT_BELOW = 1;
	localparam int RECT_LEFT  = 2;
	localparam int RECT_ABOVE = 3;

	typedef struct packed {
		logic              in_grid;
		logic [SIDX_W-1:0] sparse_index;
	} map_res_t;

endpackage

`default_nettype wire

@@ sv/full_to_sparse_grid_index.sv @@
`default_nettype none

// Full-to-sparse grid index translator. Each input word carries a linear index
// row*N+column into a full N-by-N grid, N = 2^(level+2), and yields one result
// word with the position of that point in the hyperbolic-cross sparse layout
// and an in_grid flag; points off the sparse grid, and indices at or above N*N,
// give in_grid 0 with sparse_index 0. The block takes one word per clock while
// in_stall is low: the word is captured in an input register, all level
// rectangles and the central square are compared in parallel in a single
// combinational pass, and the answer lands in a result register. While a
// finished result is stalled at the output, one more word is still taken into
// the input register. The level register sits at byte address 0 of the APB
// port (reset 4); levels above MAX_LEVEL are treated as MAX_LEVEL.
// Write level only while no word is in flight.

module full_to_sparse_grid_index import ftsg_pkg::*; #(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,

	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [IDX_W-1:0]   full_index,

	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [SIDX_W-1:0]       sparse_index,
	output logic                    in_grid,

	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0]      prdata,
	output logic                    pready
);

`include "full_to_sparse_grid_index_macros.svh"

	logic [LEVEL_W-1:0] level_q;
	logic               cfg_wr;

	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               valid_s2;
	map_res_t           res_s2;
	map_res_t           res_comb;
	logic               load_s2;

	// configuration port: zero wait states, byte offset within the word ignored
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LEVEL);
	assign prdata = (paddr[2] == REG_LEVEL) ? PDATA_W'(level_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= LEVEL_RESET;
		end else if (cfg_wr) begin
			level_q <= pwdata[LEVEL_W-1:0];
		end
	end

	// result register loads when empty or when its word is being taken
	assign load_s2  = !valid_s2 || !out_stall;
	// hold the input only when the input register is full and cannot move on
	assign in_stall = valid_s1 && !load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			idx_s1 <= full_index;
		end
		if (load_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	ftsg_map #(
		.MAX_LEVEL (MAX_LEVEL)
	) u_map (
		.level      (level_q),
		.full_index (idx_s1),
		.res        (res_comb)
	);

	assign out_valid    = valid_s2;
	assign sparse_index = res_s2.sparse_index;
	assign in_grid      = res_s2.in_grid;

	`FTSG_ASSERT(a_off_grid_zero, (out_valid && !in_grid) |-> (sparse_index == '0), "off-grid result with nonzero index")
	`FTSG_ASSERT(a_stall_needs_full, in_stall |-> (valid_s1 && valid_s2 && out_stall), "input stalled with room in the pipe")
	`FTSG_ASSERT(a_accept_fills_s1, (in_valid && !in_stall) |=> valid_s1, "accepted word lost before stage one")
	`FTSG_ASSERT(a_s1_moves_on, (valid_s1 && !out_stall) |=> out_valid, "stage one word not advanced to the output")

endmodule

`default_nettype wire

@@ sv/ftsg_map.sv @@
`default_nettype none

module ftsg_map import ftsg_pkg::*; #(
	parameter int MAX_LEVEL = MAX_LEVEL_DEF
) (
	input  wire logic [LEVEL_W-1:0] level,
	input  wire logic [IDX_W-1:0]   full_index,
	output map_res_t                res
);

	localparam int KW = MAX_LEVEL + 4;
	localparam int SW = SIDX_W;
	localparam int NR = (MAX_LEVEL + 1) / 2 + 1;

	logic [LEVEL_W-1:0]  lv;
	logic [LEVEL_W-1:0]  rmax;
	logic [LEVEL_W:0]    lsh;
	logic                in_full;
	logic [IDX_W-1:0]    row_full;
	logic [KW-1:0]       col_mask;
	logic signed [KW-1:0] half;
	logic signed [KW-1:0] k1;
	logic signed [KW-1:0] k2;
	logic signed [KW-1:0] chalf;
	logic                ctr_hit;
	logic [SW-1:0]       ctr_row;
	logic [SW-1:0]       ctr_col;
	logic [SW-1:0]       ctr_val;

	logic [NR-1:0][3:0]         hit;
	logic [NR-1:0][3:0][SW-1:0] val;

	// saturate the level and split the index into centered coordinates
	always_comb begin
		lv       = (level > LEVEL_W'(MAX_LEVEL)) ? LEVEL_W'(MAX_LEVEL) : level;
		rmax     = (lv + LEVEL_W'(1)) >> 1;
		lsh      = {1'b0, lv} + (LEVEL_W+1)'(2);
		in_full  = (full_index >> {lsh, 1'b0}) == '0;
		row_full = full_index >> lsh;
		col_mask = (KW'(1) << lsh) - KW'(1);
		half     = KW'(1) << ({1'b0, lv} + (LEVEL_W+1)'(1));
		k1       = $signed(row_full[KW-1:0]) - half;
		k2       = $signed(full_index[KW-1:0] & col_mask) - half;
	end

	// central square, row-major past all level blocks
	always_comb begin
		chalf   = KW'(1) << (lv >> 1);
		ctr_hit = in_full && (k1 >= -chalf) && (k1 < chalf)
			&& (k2 >= -chalf) && (k2 < chalf);
		ctr_row = SW'(k1 + chalf);
		ctr_col = SW'(k2 + chalf);
		ctr_val = ((SW'(rmax) + SW'(1)) << lsh)
			+ (ctr_row << ((lv >> 1) + LEVEL_W'(1))) + ctr_col;
	end

	for (genvar r = 0; r < NR; r++) begin : g_lvl
		localparam int B = 1 << r;
		localparam logic signed [KW-1:0] LO = KW'(-(B / 2));
		localparam logic signed [KW-1:0] HI = KW'((B + 1) / 2);

		logic [LEVEL_W-1:0]   sa;
		logic signed [KW-1:0] a1;
		logic signed [KW-1:0] a2;
		logic                 en;
		logic                 ge;
		logic                 gt;
		logic                 ir1, ir2, ra1, ra2, rn1, rn2;
		logic [SW-1:0]        o1, o2, p1, p2, m1, m2;
		logic [3:0]           hit_l;
		logic [3:0][SW-1:0]   val_l;

		always_comb begin
			sa  = lv - LEVEL_W'(r);
			a1  = KW'(1) << sa;
			a2  = a1 << 1;
			en  = in_full && (rmax >= LEVEL_W'(r));
			ge  = {1'b0, lv} >= (LEVEL_W+1)'(2 * r);
			gt  = {1'b0, lv} >  (LEVEL_W+1)'(2 * r);
			ir1 = (k1 >= LO) && (k1 < HI);
			ir2 = (k2 >= LO) && (k2 < HI);
			ra1 = (k1 >= a1) && (k1 < a2);
			ra2 = (k2 >= a1) && (k2 < a2);
			rn1 = (k1 >= -a2) && (k1 < -a1);
			rn2 = (k2 >= -a2) && (k2 < -a1);
			o1  = SW'(k1 - LO);
			o2  = SW'(k2 - LO);
			p1  = SW'(k1 - a1);
			p2  = SW'(k2 - a1);
			m1  = SW'(k1 + a2);
			m2  = SW'(k2 + a2);

			hit_l[RECT_RIGHT] = en && ir1 && ra2;
			hit_l[RECT_BELOW] = en && ra1 && ir2;
			hit_l[RECT_LEFT]  = en && ir1 && rn2;
			hit_l[RECT_ABOVE] = en && rn1 && ir2;

			// long side sets the scan order inside the rectangle
			val_l[RECT_RIGHT] = (SW'(4 * r + RECT_RIGHT) << lv)
				+ (ge ? (o1 << sa) + p2 : (p2 << r) + o1);
			val_l[RECT_BELOW] = (SW'(4 * r + RECT_BELOW) << lv)
				+ (gt ? (o2 << sa) + p1 : (p1 << r) + o2);
			val_l[RECT_LEFT]  = (SW'(4 * r + RECT_LEFT) << lv)
				+ (ge ? (o1 << sa) + m2 : (m2 << r) + o1);
			val_l[RECT_ABOVE] = (SW'(4 * r + RECT_ABOVE) << lv)
				+ (gt ? (o2 << sa) + m1 : (m1 << r) + o2);
		end

		assign hit[r] = hit_l;
		assign val[r] = val_l;
	end

	// first match wins: center, then lowest level, then right, below, left, above
	always_comb begin
		res = '0;
		for (int r = NR - 1; r >= 0; r--) begin
			for (int q = 3; q >= 0; q--) begin
				if (hit[r][q]) begin
					res.in_grid      = 1'b1;
					res.sparse_index = val[r][q];
				end
			end
		end
		if (ctr_hit) begin
			res.in_grid      = 1'b1;
			res.sparse_index = ctr_val;
		end
	end

endmodule

`default_nettype wire
